// ===== hw/rtl/nsa_pkg.sv =====
// Shared types and constants for the node slot array block.
// No dependencies; imported by every module of the block.
package nsa_pkg;

  localparam int KEY_CAPACITY   = 16;
  localparam int CHILD_CAPACITY = 16;
  localparam int SLOT_WIDTH     = 64;

  // Fixed field widths of the request and result
  localparam int KIND_W      = 3;
  localparam int POS_W       = 5;
  localparam int VALUE_W     = 64;
  localparam int COUNT_OUT_W = 5;
  localparam int READ_W      = 64;

  localparam int KEY_CNT_W   = $clog2(KEY_CAPACITY + 1);
  localparam int CHILD_CNT_W = $clog2(CHILD_CAPACITY + 1);
  localparam int KEY_IDX_W   = $clog2(KEY_CAPACITY);
  localparam int CHILD_IDX_W = $clog2(CHILD_CAPACITY);
  localparam int CNT_MAX_W   = (KEY_CNT_W > CHILD_CNT_W) ? KEY_CNT_W : CHILD_CNT_W;
  // Common width for index/count/capacity compares
  localparam int CMP_W       = (POS_W > CNT_MAX_W) ? POS_W : CNT_MAX_W;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Request kind codes on the stream
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_RESIZE,
    OP_READ,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_INDEX,
    ST_SIZE
  } status_t;

  // Classified request as queued between front and back
  typedef struct packed {
    op_t                    op;
    logic                   child;
    logic [POS_W-1:0]       pos;
    logic [SLOT_WIDTH-1:0]  value;
  } req_t;

endpackage

// ===== hw/rtl/nsa_front.sv =====
// Front end: accepts stream requests and classifies them into queue entries.
// Depends on nsa_pkg.
module nsa_front
  import nsa_pkg::*;
(
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [71:0]      s_tdata,   // position[4:0], entry_value[68:5], zero pad
  input  logic [3:0]       s_tuser,   // kind[2:0], array_sel[3]
  input  logic             q_full,
  output logic             q_push,
  output req_t             q_data
);

  logic [KIND_W-1:0] kind;

  assign kind     = s_tuser[2:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    case (kind)
      KIND_APPEND: q_data.op = OP_APPEND;
      KIND_INSERT: q_data.op = OP_INSERT;
      KIND_DELETE: q_data.op = OP_DELETE;
      KIND_RESIZE: q_data.op = OP_RESIZE;
      KIND_READ:   q_data.op = OP_READ;
      default:     q_data.op = OP_NONE;
    endcase
    q_data.child = s_tuser[3];
    q_data.pos   = s_tdata[POS_W-1:0];
    // only the low SLOT_WIDTH bits are ever stored
    q_data.value = SLOT_WIDTH'(s_tdata[POS_W +: VALUE_W]);
  end

endmodule

// ===== hw/rtl/nsa_fifo.sv =====
// Short request queue between front and back.
// Depends on nsa_pkg.
module nsa_fifo
  import nsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output req_t pop_data,
  output logic empty
);

  req_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full     = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/nsa_back.sv =====
// Back end: holds both slot arrays and counts, executes one request per cycle unless
// the master stream stalls, registers the result for it. Depends on nsa_pkg.
module nsa_back
  import nsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // status[1:0], key_count[6:2], child_count[11:7],
                                 // read_value[75:12], zero pad
);

  logic [SLOT_WIDTH-1:0]  key_slots   [KEY_CAPACITY];
  logic [SLOT_WIDTH-1:0]  child_slots [CHILD_CAPACITY];
  logic [SLOT_WIDTH-1:0]  key_slots_next   [KEY_CAPACITY];
  logic [SLOT_WIDTH-1:0]  child_slots_next [CHILD_CAPACITY];
  logic [KEY_CNT_W-1:0]   key_len;
  logic [KEY_CNT_W-1:0]   key_len_next;
  logic [CHILD_CNT_W-1:0] child_len;
  logic [CHILD_CNT_W-1:0] child_len_next;

  logic [CMP_W-1:0]       sel_len;
  logic [CMP_W-1:0]       sel_cap;
  logic [CMP_W-1:0]       pos_w;
  logic [CMP_W-1:0]       ins_idx;
  status_t                res_status;
  logic                   do_ok;
  logic                   key_en;
  logic                   child_en;
  logic [SLOT_WIDTH-1:0]  rd_value;

  // result register
  status_t                out_status;
  logic [COUNT_OUT_W-1:0] out_key_count;
  logic [COUNT_OUT_W-1:0] out_child_count;
  logic [READ_W-1:0]      out_read;

  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  assign pos_w   = CMP_W'(q_data.pos);
  assign sel_len = q_data.child ? CMP_W'(child_len) : CMP_W'(key_len);
  assign sel_cap = q_data.child ? CMP_W'(CHILD_CAPACITY) : CMP_W'(KEY_CAPACITY);
  assign ins_idx = (q_data.op == OP_APPEND) ? sel_len : pos_w;

  // bounds checks against the selected array
  always_comb begin
    res_status = ST_OK;
    case (q_data.op)
      OP_APPEND, OP_INSERT: begin
        if (sel_len >= sel_cap)     res_status = ST_FULL;
        else if (ins_idx > sel_len) res_status = ST_INDEX;
      end
      OP_DELETE: begin
        if (pos_w >= sel_len) res_status = ST_INDEX;
      end
      OP_RESIZE: begin
        if (pos_w > sel_cap) res_status = ST_SIZE;
      end
      OP_READ: begin
        if (pos_w >= sel_cap) res_status = ST_INDEX;
      end
      default: res_status = ST_OK;
    endcase
  end

  assign do_ok    = q_pop && (res_status == ST_OK);
  assign key_en   = do_ok && !q_data.child;
  assign child_en = do_ok && q_data.child;

  always_comb begin
    rd_value = '0;
    if (q_data.op == OP_READ && res_status == ST_OK) begin
      rd_value = q_data.child ? child_slots[pos_w[CHILD_IDX_W-1:0]]
                              : key_slots[pos_w[KEY_IDX_W-1:0]];
    end
  end

  // Per-slot next value: each slot only looks at its neighbors
  for (genvar i = 0; i < KEY_CAPACITY; i++) begin : g_key
    logic [SLOT_WIDTH-1:0] below;
    logic [SLOT_WIDTH-1:0] above;
    if (i == 0) begin : g_lo
      assign below = '0;
    end else begin : g_mid
      assign below = key_slots[i-1];
    end
    if (i == KEY_CAPACITY - 1) begin : g_top
      assign above = '0;
    end else begin : g_inner
      assign above = key_slots[i+1];
    end
    always_comb begin
      key_slots_next[i] = key_slots[i];
      if (key_en) begin
        case (q_data.op)
          OP_APPEND, OP_INSERT: begin
            if (CMP_W'(i) > ins_idx)       key_slots_next[i] = below;
            else if (CMP_W'(i) == ins_idx) key_slots_next[i] = q_data.value;
          end
          OP_DELETE: if (CMP_W'(i) >= pos_w) key_slots_next[i] = above;
          OP_RESIZE: if (CMP_W'(i) >= pos_w) key_slots_next[i] = '0;
          default:   key_slots_next[i] = key_slots[i];
        endcase
      end
    end
  end

  for (genvar i = 0; i < CHILD_CAPACITY; i++) begin : g_child
    logic [SLOT_WIDTH-1:0] below;
    logic [SLOT_WIDTH-1:0] above;
    if (i == 0) begin : g_lo
      assign below = '0;
    end else begin : g_mid
      assign below = child_slots[i-1];
    end
    if (i == CHILD_CAPACITY - 1) begin : g_top
      assign above = '0;
    end else begin : g_inner
      assign above = child_slots[i+1];
    end
    always_comb begin
      child_slots_next[i] = child_slots[i];
      if (child_en) begin
        case (q_data.op)
          OP_APPEND, OP_INSERT: begin
            if (CMP_W'(i) > ins_idx)       child_slots_next[i] = below;
            else if (CMP_W'(i) == ins_idx) child_slots_next[i] = q_data.value;
          end
          OP_DELETE: if (CMP_W'(i) >= pos_w) child_slots_next[i] = above;
          OP_RESIZE: if (CMP_W'(i) >= pos_w) child_slots_next[i] = '0;
          default:   child_slots_next[i] = child_slots[i];
        endcase
      end
    end
  end

  always_comb begin
    key_len_next   = key_len;
    child_len_next = child_len;
    if (key_en) begin
      case (q_data.op)
        OP_APPEND, OP_INSERT: key_len_next = key_len + KEY_CNT_W'(1);
        OP_DELETE:            key_len_next = key_len - KEY_CNT_W'(1);
        OP_RESIZE:            key_len_next = KEY_CNT_W'(pos_w);
        default:              key_len_next = key_len;
      endcase
    end
    if (child_en) begin
      case (q_data.op)
        OP_APPEND, OP_INSERT: child_len_next = child_len + CHILD_CNT_W'(1);
        OP_DELETE:            child_len_next = child_len - CHILD_CNT_W'(1);
        OP_RESIZE:            child_len_next = CHILD_CNT_W'(pos_w);
        default:              child_len_next = child_len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_CAPACITY; i++) key_slots[i] <= '0;
      for (int i = 0; i < CHILD_CAPACITY; i++) child_slots[i] <= '0;
      key_len   <= '0;
      child_len <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      key_slots   <= key_slots_next;
      child_slots <= child_slots_next;
      key_len     <= key_len_next;
      child_len   <= child_len_next;
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_status      <= res_status;
      out_key_count   <= COUNT_OUT_W'(key_len_next);
      out_child_count <= COUNT_OUT_W'(child_len_next);
      out_read        <= READ_W'(rd_value);
    end
  end

  assign m_tdata = {4'b0, out_read, out_child_count, out_key_count, out_status};

  // Counts never pass capacity
  a_key_len_bound: assert property (@(posedge clk) disable iff (rst)
    key_len <= KEY_CNT_W'(KEY_CAPACITY))
    else $error("key count above capacity");

  a_child_len_bound: assert property (@(posedge clk) disable iff (rst)
    child_len <= CHILD_CNT_W'(CHILD_CAPACITY))
    else $error("child count above capacity");

  // A refused request leaves both counts alone
  a_refused_no_change: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res_status != ST_OK) |=>
      (key_len == $past(key_len) && child_len == $past(child_len)))
    else $error("refused request changed a count");

  // Top key slot stays clear while the key array is not full
  a_key_top_clear: assert property (@(posedge clk) disable iff (rst)
    (key_len < KEY_CNT_W'(KEY_CAPACITY)) |-> (key_slots[KEY_CAPACITY-1] == '0))
    else $error("key slot beyond count not clear");

endmodule

// ===== hw/rtl/node_slot_array_insert_delete.sv =====
// Top level of the node slot array block: front, request queue and back.
// Depends on nsa_pkg, nsa_front, nsa_fifo, nsa_back.
//
// Keeps the key array and the child link array of one search-tree node,
// KEY_CAPACITY and CHILD_CAPACITY slots of SLOT_WIDTH bits, each with a live
// count; both clear at reset and slots at or above a count always read zero.
// Each request names one array (tuser bit 3) and a kind (tuser[2:0]):
// append, insert at index, delete at index, resize, or read one slot.
// Append or insert on a full array answers status 1, an insert or delete index
// out of range or a read at or above capacity answers 2, a resize above
// capacity answers 3; a refused request changes nothing. Every request gives
// exactly one result carrying the status, both counts after the request, and
// the slot content for a read (zero otherwise).
// Throughput is one request per clock while the master side is not stalled:
// the back end applies a whole shift at once since every slot loads from its
// neighbor in parallel. An accepted request passes through the two-entry
// request queue and then the result register before it leaves as a result.
// The queue lets the slave side keep taking requests while the master side
// is stalled, until two requests are waiting.
module node_slot_array_insert_delete
  import nsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // position[4:0], entry_value[68:5], zero pad
  input  logic [3:0]  s_tuser,   // kind[2:0], array_sel[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // status[1:0], key_count[6:2], child_count[11:7],
                                 // read_value[75:12], zero pad
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  req_t q_in;
  req_t q_out;

  nsa_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  nsa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  nsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/node_slot_array_insert_delete_tb.sv =====
// Self-checking testbench for node_slot_array_insert_delete: stream requests in,
// predicted results out. Depends on nsa_pkg and the block's RTL only.
module node_slot_array_insert_delete_tb;
  import nsa_pkg::*;

  // Kinds the block must treat as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int MAX_CAP = (KEY_CAPACITY > CHILD_CAPACITY) ? KEY_CAPACITY : CHILD_CAPACITY;
  localparam int PRINT_CAP = 40;

  // One result as seen on m_tdata
  typedef struct {
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   key_count;
    logic [COUNT_OUT_W-1:0]   child_count;
    logic [READ_W-1:0]        read_value;
  } node_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;  // position[4:0], entry_value[68:5], zero pad
  logic [3:0]  s_tuser  = '0;  // kind[2:0], array_sel[3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // status[1:0], key_count[6:2], child_count[11:7],
                               // read_value[75:12], zero pad

  // Shadow of the node: index 0 is the key array, index 1 the child links
  logic [SLOT_WIDTH-1:0] node_mem [2][MAX_CAP];
  int                    node_fill [2];

  node_result_t pending_results [$];
  node_result_t seen_r, want_r;

  int err_count     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;   // long receiver hold-off, counted down per cycle

  node_slot_array_insert_delete i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Applies one request to the shadow node and returns the result it must give
  function automatic node_result_t apply_node_request(logic [KIND_W-1:0] kind, logic sel,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VALUE_W-1:0] val);
    node_result_t r;
    int cap;
    int len;
    int idx;
    int i;
    cap = sel ? CHILD_CAPACITY : KEY_CAPACITY;
    len = node_fill[sel];
    idx = pos;
    r.status = ST_OK;
    r.read_value = '0;
    case (kind)
      KIND_APPEND, KIND_INSERT: begin
        if (kind == KIND_APPEND) idx = len;
        if (len >= cap) begin
          r.status = ST_FULL;
        end else if (idx > len) begin
          r.status = ST_INDEX;
        end else begin
          for (i = len; i > idx; i--) node_mem[sel][i] = node_mem[sel][i-1];
          node_mem[sel][idx] = val[SLOT_WIDTH-1:0];
          node_fill[sel] = len + 1;
        end
      end
      KIND_DELETE: begin
        if (idx >= len) begin
          r.status = ST_INDEX;
        end else begin
          for (i = idx; i + 1 < len; i++) node_mem[sel][i] = node_mem[sel][i+1];
          node_mem[sel][len-1] = '0;
          node_fill[sel] = len - 1;
        end
      end
      KIND_RESIZE: begin
        if (idx > cap) begin
          r.status = ST_SIZE;
        end else begin
          // dropped slots go back to zero
          for (i = idx; i < len; i++) node_mem[sel][i] = '0;
          node_fill[sel] = idx;
        end
      end
      KIND_READ: begin
        if (idx < cap) r.read_value = node_mem[sel][idx];
        else r.status = ST_INDEX;
      end
      default: ;  // spare kinds leave everything alone
    endcase
    r.key_count   = node_fill[0][COUNT_OUT_W-1:0];
    r.child_count = node_fill[1][COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("result error: %s got %0h want %0h", what, seen, want);
  endtask

  // Offers one request from a falling edge, with random idle cycles first, and
  // returns on the rising edge that accepts it. valid is never dropped between
  // back-to-back requests, so each falling edge sees one assignment at most.
  task automatic send_request(logic [KIND_W-1:0] kind, logic sel, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {sel, kind};
    s_tdata  <= {3'b000, val, pos};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_node_request(kind, sel, pos, val));
  endtask

  // Receiver: long hold-off when asked, otherwise random ready
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Each accepted result against the oldest prediction, field by field
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_r.status      = status_t'(m_tdata[1:0]);
      seen_r.key_count   = m_tdata[6:2];
      seen_r.child_count = m_tdata[11:7];
      seen_r.read_value  = m_tdata[75:12];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request", m_tdata[63:0], '0);
      end else begin
        want_r = pending_results.pop_front();
        if (seen_r.status !== want_r.status)
          report_mismatch("status", seen_r.status, want_r.status);
        if (seen_r.key_count !== want_r.key_count)
          report_mismatch("key_count", seen_r.key_count, want_r.key_count);
        if (seen_r.child_count !== want_r.child_count)
          report_mismatch("child_count", seen_r.child_count, want_r.child_count);
        if (seen_r.read_value !== want_r.read_value)
          report_mismatch("read_value", seen_r.read_value, want_r.read_value);
      end
    end
  end

  // Key array: every kind, shifts both ways, and each refusal
  task automatic test_key_array;
    send_request(KIND_READ,   1'b0, 5'd0,  '0);            // empty store reads zero
    send_request(KIND_APPEND, 1'b0, 5'd0,  '1);
    send_request(KIND_APPEND, 1'b0, 5'd31, '0);
    send_request(KIND_INSERT, 1'b0, 5'd0,  64'hA5A5_5A5A_F00D_0001); // shift up
    send_request(KIND_INSERT, 1'b0, 5'd3,  64'h8000_0000_0000_0000); // at count
    send_request(KIND_INSERT, 1'b0, 5'd5,  64'h1234);                // above count
    send_request(KIND_DELETE, 1'b0, 5'd4,  '1);                      // at count
    send_request(KIND_DELETE, 1'b0, 5'd1,  '0);                      // shift down
    send_request(KIND_READ,   1'b0, 5'd0,  '0);
    send_request(KIND_READ,   1'b0, 5'd2,  '0);
    send_request(KIND_READ,   1'b0, 5'd3,  '0);                      // vacated slot
    send_request(KIND_RESIZE, 1'b0, 5'd6,  '0);                      // grow
    send_request(KIND_READ,   1'b0, 5'd5,  '0);
    send_request(KIND_RESIZE, 1'b0, 5'd17, '0);                      // too large
    send_request(KIND_RESIZE, 1'b0, 5'd16, '0);
    send_request(KIND_APPEND, 1'b0, 5'd0,  64'h55);                  // full
    send_request(KIND_INSERT, 1'b0, 5'd0,  64'h55);                  // full
    send_request(KIND_READ,   1'b0, 5'd16, '0);                      // past capacity
    send_request(KIND_READ,   1'b0, 5'd31, '0);
    send_request(KIND_RESIZE, 1'b0, 5'd2,  '0);                      // shrink
  endtask

  // Child link array, checked apart from the keys
  task automatic test_child_array;
    send_request(KIND_APPEND, 1'b1, 5'd0,  64'hFFFF_0000_FFFF_0000);
    send_request(KIND_INSERT, 1'b1, 5'd0,  64'h0000_FFFF_0000_FFFF);
    send_request(KIND_READ,   1'b1, 5'd1,  '0);
    send_request(KIND_DELETE, 1'b1, 5'd0,  '0);
    send_request(KIND_RESIZE, 1'b1, 5'd31, '0);
    send_request(KIND_READ,   1'b1, 5'd16, '0);
  endtask

  task automatic test_spare_kinds;
    send_request(KIND_SPARE_LO, 1'b0, 5'd1,  '1);
    send_request(KIND_SPARE_HI, 1'b1, 5'd16, '1);
  endtask

  // Mostly legal requests with random content, some out of range
  task automatic test_random(int n);
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] val;
    logic               sel;
    int                 len;
    int                 cap;
    int                 roll;
    int                 pos;
    bit                 legal;
    repeat (n) begin
      sel   = $urandom_range(1, 0);
      len   = node_fill[sel];
      cap   = sel ? CHILD_CAPACITY : KEY_CAPACITY;
      roll  = $urandom_range(99, 0);
      legal = ($urandom_range(9, 0) < 8);
      pos   = $urandom_range(31, 0);
      if (roll < 25) begin
        kind = KIND_APPEND;
      end else if (roll < 50) begin
        kind = KIND_INSERT;
        if (legal) pos = $urandom_range(len, 0);
      end else if (roll < 70) begin
        kind = KIND_DELETE;
        if (legal && len > 0) pos = $urandom_range(len - 1, 0);
      end else if (roll < 78) begin
        kind = KIND_RESIZE;
        if (legal) pos = $urandom_range(cap, 0);
      end else if (roll < 98) begin
        kind = KIND_READ;
        if (legal) pos = $urandom_range(cap, 0);
      end else begin
        kind = KIND_W'($urandom_range(7, 5));
      end
      case ($urandom_range(7, 0))
        0:       val = '0;
        1:       val = '1;
        default: val = {$urandom, $urandom};
      endcase
      send_request(kind, sel, POS_W'(pos), val);
    end
  endtask

  // Receiver stalls for a long stretch while requests keep coming, so the
  // request queue fills and s_tready drops
  task automatic test_backpressure;
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles   = 60;
    repeat (12) send_request(KIND_APPEND, 1'b1, 5'd0, {$urandom, $urandom});
    repeat (12) send_request(KIND_DELETE, 1'b1, 5'd0, '0);
    send_idle_pct = saved_idle;
  endtask

  initial begin
    node_fill[0] = 0;
    node_fill[1] = 0;
    for (int i = 0; i < MAX_CAP; i++) begin
      node_mem[0][i] = '0;
      node_mem[1][i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 72;
    test_key_array();
    test_child_array();
    test_spare_kinds();
    test_random(200);
    test_backpressure();

    send_idle_pct = 72;
    recv_idle_pct = 30;
    test_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("node_slot_array_insert_delete: match");
    end else begin
      $display("node_slot_array_insert_delete: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("node_slot_array_insert_delete: mismatch");
    $finish;
  end

endmodule

// ===== node_slot_array_insert_delete.f =====
hw/rtl/nsa_pkg.sv
hw/rtl/nsa_front.sv
hw/rtl/nsa_fifo.sv
hw/rtl/nsa_back.sv
hw/rtl/node_slot_array_insert_delete.sv
tb/node_slot_array_insert_delete_tb.sv
